// ===== rtl/core/shc_pkg.sv =====
`timescale 1ns / 1ps

package shc_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned HASH_W = 32;
   localparam int unsigned COUNT_W = 3;

   localparam logic [HASH_W-1:0] POLY_RESET = 32'h04C1_1DB7;
   localparam logic [HASH_W-1:0] HASH_MSB = 32'h8000_0000;
   localparam logic [COUNT_W-1:0] COUNT_FULL = 3'd4;
   localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

   // one byte waiting in the input register
   typedef struct packed {
      logic valid;
      logic [BYTE_W-1:0] char_byte;
   } shc_beat_type;

   // msb-first remainder of one byte, eight shift-xor steps
   function automatic logic [HASH_W-1:0] byte_remainder(
      input logic [BYTE_W-1:0] top,
      input logic [HASH_W-1:0] poly
   );
      logic [HASH_W-1:0] r;
      r = {top, {(HASH_W-BYTE_W){1'b0}}};
      for (int k = 0; k < BYTE_W; k++) begin
         if ((r & HASH_MSB) != '0) begin
            r = {r[HASH_W-2:0], 1'b0} ^ poly;
         end else begin
            r = {r[HASH_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/shc_if.sv =====
`timescale 1ns / 1ps

// byte request channel
interface shc_req_if;
   logic valid;
   logic ready;
   logic [shc_pkg::BYTE_W-1:0] char_byte;
   modport source (output valid, output char_byte, input ready);
   modport sink (input valid, input char_byte, output ready);
endinterface

// hash response channel
interface shc_rsp_if;
   logic valid;
   logic ready;
   logic [shc_pkg::HASH_W-1:0] hash_value;
   modport source (output valid, output hash_value, input ready);
   modport sink (input valid, input hash_value, output ready);
endinterface

// polynomial write channel
interface shc_csr_if;
   logic valid;
   logic ready;
   logic [shc_pkg::HASH_W-1:0] crc_polynomial;
   modport source (output valid, output crc_polynomial, input ready);
   modport sink (input valid, input crc_polynomial, output ready);
endinterface

// ===== rtl/core/shc_in_stage.sv =====
`timescale 1ns / 1ps

module shc_in_stage (
   input  logic                 clock,
   input  logic                 reset,
   shc_req_if.sink              req_chan,
   output shc_pkg::shc_beat_type beat,
   input  logic                 take
);
   import shc_pkg::*;

   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              accept;

   // register is free when empty or being drained this cycle
   assign req_chan.ready = !valid_ff || take;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in = byte_ff;
      if (accept) begin
         valid_in = 1'b1;
         byte_in = req_chan.char_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid = valid_ff;
   assign beat.char_byte = byte_ff;

endmodule

// ===== rtl/core/shc_core.sv =====
`timescale 1ns / 1ps

module shc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  shc_pkg::shc_beat_type beat,
   output logic                 take,
   shc_csr_if.sink              csr_chan,
   shc_rsp_if.source            rsp_chan
);
   import shc_pkg::*;

   logic [HASH_W-1:0]  poly_ff, poly_in;
   logic [HASH_W-1:0]  acc_ff, acc_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic               is_term;
   logic [HASH_W-1:0]  packed_word;

   // polynomial register, always writable
   assign csr_chan.ready = 1'b1;
   assign poly_in = csr_chan.valid ? csr_chan.crc_polynomial : poly_ff;

   // a terminator needs the result register free, other bytes never wait
   assign is_term = (beat.char_byte == TERMINATOR);
   assign take = beat.valid && (!is_term || !rsp_valid_ff || rsp_chan.ready);

   // place the byte into its slot while packing; the fourth byte also inverts the word
   always_comb begin
      case (count_ff[1:0])
         2'd0:    packed_word = acc_ff | {beat.char_byte, 24'h0};
         2'd1:    packed_word = acc_ff | {8'h0, beat.char_byte, 16'h0};
         2'd2:    packed_word = acc_ff | {16'h0, beat.char_byte, 8'h0};
         default: packed_word = ~(acc_ff | {24'h0, beat.char_byte});
      endcase
   end

   // next accumulator, count and result
   always_comb begin
      acc_in = acc_ff;
      count_in = count_ff;
      hash_in = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (take) begin
         if (is_term) begin
            if (count_ff == '0) begin
               hash_in = '0;
            end else if (count_ff < COUNT_FULL) begin
               hash_in = acc_ff;
            end else begin
               hash_in = ~acc_ff;
            end
            rsp_valid_in = 1'b1;
            acc_in = '0;
            count_in = '0;
         end else if (count_ff < COUNT_FULL) begin
            acc_in = packed_word;
            count_in = count_ff + 1'b1;
         end else begin
            acc_in = {acc_ff[HASH_W-BYTE_W-1:0], beat.char_byte}
                     ^ byte_remainder(acc_ff[HASH_W-1 -: BYTE_W], poly_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= POLY_RESET;
         acc_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         poly_ff <= poly_in;
         acc_ff <= acc_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hash_ff <= hash_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.hash_value = hash_ff;

endmodule

// ===== rtl/core/string_crc32_hash.sv =====
`timescale 1ns / 1ps
// path: a terminator byte is held in the input register, then its hash goes to the result register
// throughput: one byte per cycle unless a terminator waits; from a string's fifth byte on,
// each update is one eight-step shift-xor remainder between input register and accumulator
// a terminator waits in the input register only while an earlier hash is not taken
// reset: synchronous, active high; clears the string state, restores the polynomial

module string_crc32_hash (
   input logic       clock,
   input logic       reset,
   shc_req_if.sink   req_chan,
   shc_rsp_if.source rsp_chan,
   shc_csr_if.sink   csr_chan
);
   import shc_pkg::*;

   shc_beat_type beat;
   logic         take;

   shc_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .beat     (beat),
      .take     (take)
   );

   shc_core u_core (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat),
      .take     (take),
      .csr_chan (csr_chan),
      .rsp_chan (rsp_chan)
   );

`ifndef NO_ASSERTIONS
   // backpressure only while a byte is held
   a_ready_held : assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> beat.valid)
      else $error("request stalled with empty input register");

   // a held byte that is not consumed stays in place
   a_beat_hold : assert property (@(posedge clock) disable iff (reset)
      beat.valid && !take |=> beat.valid && $stable(beat.char_byte))
      else $error("held byte lost or changed");

   // a consumed terminator always shows a hash
   a_term_hash : assert property (@(posedge clock) disable iff (reset)
      take && beat.char_byte == TERMINATOR |=> rsp_chan.valid)
      else $error("terminator gave no hash");

   // nonzero bytes never wait
   a_byte_flow : assert property (@(posedge clock) disable iff (reset)
      beat.valid && beat.char_byte != TERMINATOR |-> take)
      else $error("data byte stalled");
`endif

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import shc_pkg::*;

   localparam int IDLE_LIMIT = 4000;
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_BYTES = 210;
   localparam int NUM_PHASES = 8;

   // running string hash and the hashes still owed by the block
   class hash_scoreboard;
      logic [HASH_W-1:0] poly;
      logic [HASH_W-1:0] acc;
      logic [COUNT_W-1:0] loaded;
      logic [HASH_W-1:0] owed_hashes[$];
      int failures;
      int shown;

      function new();
         poly = POLY_RESET;
         acc = '0;
         loaded = '0;
         failures = 0;
         shown = 0;
      endfunction

      // msb-first crc remainder of one top byte under the current polynomial
      function logic [HASH_W-1:0] top_fold(logic [BYTE_W-1:0] top);
         logic [HASH_W-1:0] r;
         r = {top, 24'h000000};
         for (int k = 0; k < 8; k++) begin
            if (r[HASH_W-1]) begin
               r = (r << 1) ^ poly;
            end else begin
               r = r << 1;
            end
         end
         return r;
      endfunction

      // one accepted string byte
      function void note_byte(logic [BYTE_W-1:0] b);
         logic [HASH_W-1:0] h;
         int shift;
         if (b == TERMINATOR) begin
            if (loaded == 0) h = '0;
            else if (loaded < COUNT_FULL) h = acc;
            else h = ~acc;
            owed_hashes.push_back(h);
            acc = '0;
            loaded = '0;
         end else if (loaded < COUNT_FULL) begin
            shift = 24 - 8 * int'(loaded);
            acc = acc | ({24'h000000, b} << shift);
            loaded = loaded + 1'b1;
            if (loaded == COUNT_FULL) acc = ~acc;
         end else begin
            acc = {acc[HASH_W-9:0], b} ^ top_fold(acc[HASH_W-1:HASH_W-8]);
         end
      endfunction

      // one accepted hash beat
      function void check_hash(logic [HASH_W-1:0] got);
         logic [HASH_W-1:0] want;
         if (owed_hashes.size() == 0) begin
            failures++;
            if (shown < 10) begin
               shown++;
               $display("unexpected hash beat: got %h", got);
            end
         end else begin
            want = owed_hashes.pop_front();
            if (want !== got) begin
               failures++;
               if (shown < 10) begin
                  shown++;
                  $display("hash mismatch: expected %h, got %h", want, got);
               end
            end
         end
      endfunction

      function int owed();
         return owed_hashes.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   shc_req_if req ();
   shc_rsp_if rsp ();
   shc_csr_if csr ();

   string_crc32_hash dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp),
      .csr_chan (csr)
   );

   hash_scoreboard sb = new();

   int send_idle = 0;
   int recv_stall = 0;
   int send_pct[4] = '{0, 80, 0, 24};
   int recv_pct[4] = '{0, 0, 80, 24};

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: check accepted beats, stall at random
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp.valid && rsp.ready) sb.check_hash(rsp.hash_value);
         rsp.ready <= ($urandom_range(99) >= recv_stall);
      end
   end

   // watchdog on cycles with no beat on any channel
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) ||
             (csr.valid && csr.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("status: fail");
      $finish;
   end

   // one byte beat, with a random gap in front of it
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      if ($urandom_range(99) < send_idle) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req.valid <= 1'b1;
      req.char_byte <= b;
      do @(posedge clock); while (!req.ready);
      sb.note_byte(b);
   endtask

   // sender holds off until every owed hash has come back
   task automatic drain_hashes();
      req.valid <= 1'b0;
      do @(posedge clock); while (sb.owed() != 0);
   endtask

   // block idle, including a trailing non-terminator byte in flight
   task automatic settle();
      drain_hashes();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_poly(input logic [HASH_W-1:0] value);
      csr.valid <= 1'b1;
      csr.crc_polynomial <= value;
      do @(posedge clock); while (!csr.ready);
      sb.poly = value;
      csr.valid <= 1'b0;
   endtask

   task automatic send_list(input logic [BYTE_W-1:0] bytes[]);
      foreach (bytes[i]) send_byte(bytes[i]);
   endtask

   // random nonzero bytes, optionally closed by a terminator
   task automatic send_string(input int len, input bit close);
      for (int i = 0; i < len; i++) send_byte(BYTE_W'($urandom_range(255, 1)));
      if (close) send_byte(TERMINATOR);
   endtask

   function automatic int pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 12) return $urandom_range(3, 0);
      else if (r < 80) return $urandom_range(12, 4);
      else return $urandom_range(40, 13);
   endfunction

   initial begin
      logic [BYTE_W-1:0] opening[];
      logic [BYTE_W-1:0] closing[];
      logic [HASH_W-1:0] poly_after[7];
      int sent;
      int len;

      reset <= 1'b1;
      req.valid <= 1'b0;
      req.char_byte <= '0;
      csr.valid <= 1'b0;
      csr.crc_polynomial <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty, short, exactly four, longer, then a string cut by a new polynomial
      opening = '{8'h00,
                  8'hFF, 8'h00,
                  8'h01, 8'h80, 8'hFF, 8'h00,
                  8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00,
                  8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55, 8'hAA, 8'h00,
                  8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
      closing = '{8'hBC, 8'hDE, 8'h00};
      send_list(opening);
      settle();
      write_poly(32'hFFFF_FFFF);
      send_list(closing);
      settle();

      poly_after[0] = 32'h0000_0000;
      poly_after[1] = $urandom;
      poly_after[2] = HASH_MSB;
      poly_after[3] = 32'h0000_0001;
      poly_after[4] = $urandom;
      poly_after[5] = POLY_RESET;
      poly_after[6] = 32'hFFFF_FFFF;

      // random strings over the idle modes and polynomials
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         send_idle = send_pct[ph % 4];
         recv_stall = recv_pct[ph % 4];
         sent = 0;
         while (sent < PHASE_BYTES) begin
            len = pick_length();
            send_string(len, 1'b1);
            sent += len + 1;
            if ($urandom_range(39) == 0) drain_hashes();
         end
         if (ph < NUM_PHASES - 1) begin
            // half the time leave a string open across the polynomial change
            if ($urandom_range(1) == 1) send_string($urandom_range(7, 1), 1'b0);
            settle();
            write_poly(poly_after[ph]);
         end
      end
      send_byte(TERMINATOR);

      // drain and let the pipeline empty
      drain_hashes();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.owed() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/shc_pkg.sv
rtl/core/shc_if.sv
rtl/core/shc_in_stage.sv
rtl/core/shc_core.sv
rtl/core/string_crc32_hash.sv
sim/tb.sv
